@@ rtl/obbsat_pkg.sv @@
// Shared types for the rotated-box versus axis-aligned-box overlap test.
package obbsat_pkg;

    typedef struct packed {
        logic en;
        logic vld;
    } t_stage_ctl;

endpackage

@@ rtl/obbsat_axis.sv @@
// Projection and interval overlap check of both boxes on one rotated axis.
module obbsat_axis #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  obbsat_pkg::t_stage_ctl        i_ctl,
    input  logic signed [COORD_WIDTH:0]   i_ax,
    input  logic signed [COORD_WIDTH:0]   i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_ox [4],
    input  logic signed [COORD_WIDTH-1:0] i_oy [4],
    input  logic signed [COORD_WIDTH-1:0] i_box_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_y,
    output logic                          o_overlap
);

    localparam int PW = 2 * COORD_WIDTH + 1;
    localparam int SW = PW + 1;

    logic signed [PW-1:0] r_c_px [4];
    logic signed [PW-1:0] r_c_py [4];
    logic signed [PW-1:0] r_c_bx0, r_c_bx1, r_c_by0, r_c_by1;
    logic signed [PW-1:0] n_c_px [4];
    logic signed [PW-1:0] n_c_py [4];

    logic signed [SW-1:0] r_d_s [4];
    logic signed [SW-1:0] r_d_blo, r_d_bhi;
    logic signed [SW-1:0] n_d_s [4];
    logic signed [SW-1:0] n_d_blo, n_d_bhi;

    logic signed [SW-1:0] s_lo, s_hi;

    // products
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_c_px[i] = PW'(i_ax) * PW'(i_ox[i]);
            n_c_py[i] = PW'(i_ay) * PW'(i_oy[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && i_ctl.vld) begin
            r_c_px  <= n_c_px;
            r_c_py  <= n_c_py;
            r_c_bx0 <= PW'(i_ax) * PW'(i_box_min_x);
            r_c_bx1 <= PW'(i_ax) * PW'(i_box_max_x);
            r_c_by0 <= PW'(i_ay) * PW'(i_box_min_y);
            r_c_by1 <= PW'(i_ay) * PW'(i_box_max_y);
        end
    end

    // corner sums and box interval
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_d_s[i] = SW'(r_c_px[i]) + SW'(r_c_py[i]);
        end
        n_d_blo = SW'((r_c_bx0 < r_c_bx1) ? r_c_bx0 : r_c_bx1)
                + SW'((r_c_by0 < r_c_by1) ? r_c_by0 : r_c_by1);
        n_d_bhi = SW'((r_c_bx0 < r_c_bx1) ? r_c_bx1 : r_c_bx0)
                + SW'((r_c_by0 < r_c_by1) ? r_c_by1 : r_c_by0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_d_s   <= n_d_s;
            r_d_blo <= n_d_blo;
            r_d_bhi <= n_d_bhi;
        end
    end

    always_comb begin
        s_lo = r_d_s[0];
        s_hi = r_d_s[0];
        for (int i = 1; i < 4; i++) begin
            if (r_d_s[i] < s_lo) s_lo = r_d_s[i];
            if (r_d_s[i] > s_hi) s_hi = r_d_s[i];
        end
        o_overlap = (r_d_blo < s_hi) && (s_lo < r_d_bhi);
    end

endmodule

@@ rtl/obb_aabb_overlap_test_unit.sv @@
// Top level: separating axis overlap test of a rotated box against an axis-aligned box.
//
// Input channel: i_valid / o_stall carry one query (four rotated-box corners and
// the axis-aligned box bounds, signed COORD_WIDTH-bit fixed point). A transfer
// happens on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry o_hit, high when the projections of
// both boxes overlap strictly on world x, world y and both rotated edge axes.
// The query passes five registers in order: input, edge vectors and world-axis
// checks, products, sums, result; o_valid is the valid bit of the result register.
// One query per cycle unless the output stalls; the whole pipeline advances together.
// When the receiver stalls a waiting result, the pipeline freezes and o_stall
// rises in the same cycle; the result holds until transferred.
// Reset (synchronous, active low) empties the pipeline; data registers are not reset.
module obb_aabb_overlap_test_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_obb_tl_x,
    input  logic signed [COORD_WIDTH-1:0] i_obb_tl_y,
    input  logic signed [COORD_WIDTH-1:0] i_obb_tr_x,
    input  logic signed [COORD_WIDTH-1:0] i_obb_tr_y,
    input  logic signed [COORD_WIDTH-1:0] i_obb_bl_x,
    input  logic signed [COORD_WIDTH-1:0] i_obb_bl_y,
    input  logic signed [COORD_WIDTH-1:0] i_obb_br_x,
    input  logic signed [COORD_WIDTH-1:0] i_obb_br_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit
);

    localparam int W = COORD_WIDTH;

    logic en;
    obbsat_pkg::t_stage_ctl s_ctl;

    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d, r_vld_e;

    logic signed [W-1:0] r_a_ox [4];
    logic signed [W-1:0] r_a_oy [4];
    logic signed [W-1:0] r_a_mnx, r_a_mny, r_a_mxx, r_a_mxy;

    logic signed [W-1:0] r_b_ox [4];
    logic signed [W-1:0] r_b_oy [4];
    logic signed [W-1:0] r_b_mnx, r_b_mny, r_b_mxx, r_b_mxy;
    logic signed [W:0]   r_b_ux, r_b_uy, r_b_vx, r_b_vy;
    logic                r_b_xy_ok, r_c_xy_ok, r_d_xy_ok;
    logic                n_b_xy_ok;

    logic signed [W-1:0] ox_lo, ox_hi, oy_lo, oy_hi;
    logic signed [W-1:0] bx_lo, bx_hi, by_lo, by_hi;

    logic u_ok, v_ok;
    logic r_hit;

    assign en      = !r_vld_e || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld_e;
    assign o_hit   = r_hit;
    assign s_ctl   = '{en: en, vld: r_vld_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
        end else if (en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
            r_vld_d <= r_vld_c;
            r_vld_e <= r_vld_d;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_a_ox[0] <= i_obb_tl_x;
            r_a_oy[0] <= i_obb_tl_y;
            r_a_ox[1] <= i_obb_tr_x;
            r_a_oy[1] <= i_obb_tr_y;
            r_a_ox[2] <= i_obb_bl_x;
            r_a_oy[2] <= i_obb_bl_y;
            r_a_ox[3] <= i_obb_br_x;
            r_a_oy[3] <= i_obb_br_y;
            r_a_mnx   <= i_box_min_x;
            r_a_mny   <= i_box_min_y;
            r_a_mxx   <= i_box_max_x;
            r_a_mxy   <= i_box_max_y;
        end
    end

    // world-axis intervals
    always_comb begin
        ox_lo = r_a_ox[0];
        ox_hi = r_a_ox[0];
        oy_lo = r_a_oy[0];
        oy_hi = r_a_oy[0];
        for (int i = 1; i < 4; i++) begin
            if (r_a_ox[i] < ox_lo) ox_lo = r_a_ox[i];
            if (r_a_ox[i] > ox_hi) ox_hi = r_a_ox[i];
            if (r_a_oy[i] < oy_lo) oy_lo = r_a_oy[i];
            if (r_a_oy[i] > oy_hi) oy_hi = r_a_oy[i];
        end
        bx_lo = (r_a_mnx < r_a_mxx) ? r_a_mnx : r_a_mxx;
        bx_hi = (r_a_mnx < r_a_mxx) ? r_a_mxx : r_a_mnx;
        by_lo = (r_a_mny < r_a_mxy) ? r_a_mny : r_a_mxy;
        by_hi = (r_a_mny < r_a_mxy) ? r_a_mxy : r_a_mny;
        n_b_xy_ok = (bx_lo < ox_hi) && (ox_lo < bx_hi)
                 && (by_lo < oy_hi) && (oy_lo < by_hi);
    end

    always_ff @(posedge i_clk) begin
        if (en && r_vld_a) begin
            r_b_ox    <= r_a_ox;
            r_b_oy    <= r_a_oy;
            r_b_mnx   <= r_a_mnx;
            r_b_mny   <= r_a_mny;
            r_b_mxx   <= r_a_mxx;
            r_b_mxy   <= r_a_mxy;
            r_b_ux    <= (W+1)'(r_a_ox[1]) - (W+1)'(r_a_ox[0]);
            r_b_uy    <= (W+1)'(r_a_oy[1]) - (W+1)'(r_a_oy[0]);
            r_b_vx    <= (W+1)'(r_a_ox[2]) - (W+1)'(r_a_ox[0]);
            r_b_vy    <= (W+1)'(r_a_oy[2]) - (W+1)'(r_a_oy[0]);
            r_b_xy_ok <= n_b_xy_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_xy_ok <= r_b_xy_ok;
            r_d_xy_ok <= r_c_xy_ok;
            r_hit     <= r_d_xy_ok && u_ok && v_ok;
        end
    end

    obbsat_axis #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_axis_u (
        .i_clk       (i_clk),
        .i_ctl       (s_ctl),
        .i_ax        (r_b_ux),
        .i_ay        (r_b_uy),
        .i_ox        (r_b_ox),
        .i_oy        (r_b_oy),
        .i_box_min_x (r_b_mnx),
        .i_box_max_x (r_b_mxx),
        .i_box_min_y (r_b_mny),
        .i_box_max_y (r_b_mxy),
        .o_overlap   (u_ok)
    );

    obbsat_axis #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_axis_v (
        .i_clk       (i_clk),
        .i_ctl       (s_ctl),
        .i_ax        (r_b_vx),
        .i_ay        (r_b_vy),
        .i_ox        (r_b_ox),
        .i_oy        (r_b_oy),
        .i_box_min_x (r_b_mnx),
        .i_box_max_x (r_b_mxx),
        .i_box_min_y (r_b_mny),
        .i_box_max_y (r_b_mxy),
        .o_overlap   (v_ok)
    );

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld_e && i_stall))
        else $error("input stalled without a blocked result");

    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld_d) |=> r_vld_e)
        else $error("item lost between last stage and output");

    a_xy_miss_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld_d && !r_d_xy_ok) |=> !o_hit)
        else $error("hit reported with a world-axis separation");

endmodule

@@ verif/testbench.sv @@
// Testbench for obb_aabb_overlap_test_unit: directed and random queries, local SAT predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int CW          = 16;
    localparam int LATENCY     = 5;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic signed [CW-1:0] tl_x;
        logic signed [CW-1:0] tl_y;
        logic signed [CW-1:0] tr_x;
        logic signed [CW-1:0] tr_y;
        logic signed [CW-1:0] bl_x;
        logic signed [CW-1:0] bl_y;
        logic signed [CW-1:0] br_x;
        logic signed [CW-1:0] br_y;
        logic signed [CW-1:0] min_x;
        logic signed [CW-1:0] min_y;
        logic signed [CW-1:0] max_x;
        logic signed [CW-1:0] max_y;
    } t_query;

    typedef struct {
        int unsigned query_num;
        bit          hit;
    } t_expected_hit;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [CW-1:0] i_obb_tl_x;
    logic signed [CW-1:0] i_obb_tl_y;
    logic signed [CW-1:0] i_obb_tr_x;
    logic signed [CW-1:0] i_obb_tr_y;
    logic signed [CW-1:0] i_obb_bl_x;
    logic signed [CW-1:0] i_obb_bl_y;
    logic signed [CW-1:0] i_obb_br_x;
    logic signed [CW-1:0] i_obb_br_y;
    logic signed [CW-1:0] i_box_min_x;
    logic signed [CW-1:0] i_box_min_y;
    logic signed [CW-1:0] i_box_max_x;
    logic signed [CW-1:0] i_box_max_y;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_hit;

    t_expected_hit pending_hits[$];
    int unsigned   queries_sent;
    int unsigned   mismatch_count;
    int unsigned   send_idle_pct;
    int unsigned   recv_stall_pct;
    int            stall_hold;
    int            quiet_cycles;

    obb_aabb_overlap_test_unit #(
        .COORD_WIDTH(CW)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_obb_tl_x (i_obb_tl_x),
        .i_obb_tl_y (i_obb_tl_y),
        .i_obb_tr_x (i_obb_tr_x),
        .i_obb_tr_y (i_obb_tr_y),
        .i_obb_bl_x (i_obb_bl_x),
        .i_obb_bl_y (i_obb_bl_y),
        .i_obb_br_x (i_obb_br_x),
        .i_obb_br_y (i_obb_br_y),
        .i_box_min_x(i_box_min_x),
        .i_box_min_y(i_box_min_y),
        .i_box_max_x(i_box_max_x),
        .i_box_max_y(i_box_max_y),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_hit      (o_hit)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit overlap_on_axis(t_query q, longint ax, longint ay);
        longint ox[4];
        longint oy[4];
        longint bx[4];
        longint by[4];
        longint p;
        longint obb_lo;
        longint obb_hi;
        longint box_lo;
        longint box_hi;
        int     i;
        ox = '{q.tl_x, q.tr_x, q.bl_x, q.br_x};
        oy = '{q.tl_y, q.tr_y, q.bl_y, q.br_y};
        bx = '{q.min_x, q.max_x, q.min_x, q.max_x};
        by = '{q.min_y, q.min_y, q.max_y, q.max_y};
        for (i = 0; i < 4; i++) begin
            p = ox[i] * ax + oy[i] * ay;
            if (i == 0 || p < obb_lo) obb_lo = p;
            if (i == 0 || p > obb_hi) obb_hi = p;
            p = bx[i] * ax + by[i] * ay;
            if (i == 0 || p < box_lo) box_lo = p;
            if (i == 0 || p > box_hi) box_hi = p;
        end
        return (box_lo < obb_hi) && (obb_lo < box_hi);
    endfunction

    function automatic bit predict_hit(t_query q);
        longint ux;
        longint uy;
        longint vx;
        longint vy;
        ux = longint'(q.tr_x) - longint'(q.tl_x);
        uy = longint'(q.tr_y) - longint'(q.tl_y);
        vx = longint'(q.bl_x) - longint'(q.tl_x);
        vy = longint'(q.bl_y) - longint'(q.tl_y);
        return overlap_on_axis(q, 64'sd1, 64'sd0) && overlap_on_axis(q, 64'sd0, 64'sd1)
            && overlap_on_axis(q, ux, uy) && overlap_on_axis(q, vx, vy);
    endfunction

    function automatic t_query corner_query(int tlx, int tly, int trx, int tr_y,
                                            int blx, int bly, int brx, int bry,
                                            int mnx, int mny, int mxx, int mxy);
        t_query q;
        q.tl_x  = CW'(tlx);
        q.tl_y  = CW'(tly);
        q.tr_x  = CW'(trx);
        q.tr_y  = CW'(tr_y);
        q.bl_x  = CW'(blx);
        q.bl_y  = CW'(bly);
        q.br_x  = CW'(brx);
        q.br_y  = CW'(bry);
        q.min_x = CW'(mnx);
        q.min_y = CW'(mny);
        q.max_x = CW'(mxx);
        q.max_y = CW'(mxy);
        return q;
    endfunction

    function automatic t_query rect_query(int tlx, int tly, int ux, int uy, int vx, int vy,
                                          int mnx, int mny, int mxx, int mxy);
        return corner_query(tlx, tly, tlx + ux, tly + uy, tlx + vx, tly + vy,
                            tlx + ux + vx, tly + uy + vy, mnx, mny, mxx, mxy);
    endfunction

    function automatic int near_coord(int reach);
        return int'($urandom_range(2 * reach)) - reach;
    endfunction

    function automatic t_query rand_query();
        int unsigned pick;
        int          a;
        int          b;
        int          m;
        int          n;
        int          tlx;
        int          tly;
        int          mnx;
        int          mny;
        int          sx;
        int          sy;
        t_query      q;
        pick = $urandom_range(99);
        if (pick < 15) begin
            q = t_query'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            return q;
        end
        if (pick < 30) begin
            q = corner_query(near_coord(600), near_coord(600), near_coord(600), near_coord(600),
                             near_coord(600), near_coord(600), near_coord(600), near_coord(600),
                             near_coord(600), near_coord(600), near_coord(600), near_coord(600));
            return q;
        end
        if (pick < 60) begin
            // grid-aligned small shapes: touching projections show up often
            a   = near_coord(2);
            b   = near_coord(2);
            m   = 16 * int'($urandom_range(1, 6));
            n   = 16 * int'($urandom_range(1, 6));
            tlx = 16 * near_coord(16);
            tly = 16 * near_coord(16);
            mnx = 16 * near_coord(16);
            mny = 16 * near_coord(16);
            sx  = 16 * int'($urandom_range(20));
            sy  = 16 * int'($urandom_range(20));
        end else begin
            a   = near_coord(64);
            b   = near_coord(64);
            m   = $urandom_range(1, 8);
            n   = $urandom_range(1, 8);
            tlx = near_coord(400);
            tly = near_coord(400);
            mnx = near_coord(500);
            mny = near_coord(500);
            sx  = $urandom_range(600);
            sy  = $urandom_range(600);
        end
        q = rect_query(tlx, tly, a * m, b * m, -b * n, a * n, mnx, mny, mnx + sx, mny + sy);
        if ($urandom_range(9) == 0) {q.min_x, q.max_x} = {q.max_x, q.min_x};
        if ($urandom_range(9) == 0) {q.min_y, q.max_y} = {q.max_y, q.min_y};
        return q;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic send_query(t_query q);
        t_expected_hit entry;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_obb_tl_x  <= q.tl_x;
        i_obb_tl_y  <= q.tl_y;
        i_obb_tr_x  <= q.tr_x;
        i_obb_tr_y  <= q.tr_y;
        i_obb_bl_x  <= q.bl_x;
        i_obb_bl_y  <= q.bl_y;
        i_obb_br_x  <= q.br_x;
        i_obb_br_y  <= q.br_y;
        i_box_min_x <= q.min_x;
        i_box_min_y <= q.min_y;
        i_box_max_x <= q.max_x;
        i_box_max_y <= q.max_y;
        do @(posedge i_clk); while (o_stall);
        entry.query_num = queries_sent;
        entry.hit       = predict_hit(q);
        pending_hits.push_back(entry);
        queries_sent++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (pending_hits.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_query(rect_query(0, 0, 160, 0, 0, 160, 80, 80, 320, 320));
        send_query(rect_query(0, 0, 160, 0, 0, 160, 400, 0, 500, 100));
        send_query(rect_query(0, 0, 160, 0, 0, 160, 0, 400, 100, 500));
        // touching edges do not count
        send_query(rect_query(0, 0, 160, 0, 0, 160, 160, 0, 300, 100));
        send_query(rect_query(0, 0, 160, 0, 0, 160, -100, -100, 0, 0));
        // diamond: separated only on an edge axis, overlapping, touching on it
        send_query(rect_query(0, -100, 100, 100, -100, 100, 60, 60, 200, 200));
        send_query(rect_query(0, -100, 100, 100, -100, 100, 40, 40, 200, 200));
        send_query(rect_query(0, -100, 100, 100, -100, 100, 50, 50, 200, 200));
        // coincident corners collapse an edge axis
        send_query(corner_query(0, 0, 0, 0, 0, 160, 160, 160, -50, -50, 300, 300));
        send_query(corner_query(0, 0, 160, 0, 0, 0, 160, 160, -50, -50, 300, 300));
        send_query(corner_query(40, 40, 40, 40, 40, 40, 40, 40, 0, 0, 100, 100));
        // swapped bounds
        send_query(rect_query(0, 0, 160, 0, 0, 160, 320, 320, 80, 80));
        send_query(rect_query(0, 0, 160, 0, 0, 160, 900, 60, 400, 20));
        // not a rectangle
        send_query(corner_query(0, 0, 200, 30, -40, 150, 90, -60, 10, 10, 50, 50));
        send_query(corner_query(0, 0, 200, 30, -40, 150, 90, -60, 300, 300, 400, 400));
        // extremes of the coordinate range
        send_query(corner_query(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768, -32768));
        send_query(corner_query(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767, 32767));
        send_query(corner_query(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767,
                                -32768, -32768, 32767, 32767));
        send_query(corner_query(-32768, 0, 0, -32768, 0, 32767, 32767, 0,
                                -100, -100, 100, 100));
        send_query(corner_query(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767,
                                32767, 32767, -32768, -32768));
        // point box: strictly inside, then on an edge; last, a box equal to the rotated box
        send_query(rect_query(0, -100, 100, 100, -100, 100, 10, 20, 10, 20));
        send_query(rect_query(0, -100, 100, 100, -100, 100, 50, 50, 50, 50));
        send_query(rect_query(0, 0, 160, 0, 0, 160, 0, 0, 160, 160));
    endtask

    task automatic test_random_traffic();
        int unsigned send_pcts[4] = '{0, 52, 0, 32};
        int unsigned recv_pcts[4] = '{0, 0, 52, 32};
        int          phase;
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            repeat (345) send_query(rand_query());
        end
    endtask

    task automatic test_stall_fill();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stall_hold     = LONG_HOLD;
        repeat (40) send_query(rand_query());
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        repeat (12) send_query(rand_query());
        release_input();
        wait_results_drained();
        repeat (12) send_query(rand_query());
    endtask

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_hold > 0) begin
                i_stall <= 1'b1;
                stall_hold--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_expected_hit head;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_hits.size() == 0) begin
                report_mismatch("result transfer with no query outstanding");
            end else begin
                head = pending_hits.pop_front();
                if (o_hit !== head.hit)
                    report_mismatch($sformatf("query %0d: o_hit %b, expected %b",
                                              head.query_num, o_hit, head.hit));
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TIMEOUT: no transfer in %0d cycles", QUIET_LIMIT);
        $display("obb_aabb_overlap_test_unit verification failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_obb_tl_x     = '0;
        i_obb_tl_y     = '0;
        i_obb_tr_x     = '0;
        i_obb_tr_y     = '0;
        i_obb_bl_x     = '0;
        i_obb_bl_y     = '0;
        i_obb_br_x     = '0;
        i_obb_br_y     = '0;
        i_box_min_x    = '0;
        i_box_min_y    = '0;
        i_box_max_x    = '0;
        i_box_max_y    = '0;
        queries_sent   = 0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stall_hold     = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_stall_fill();
        test_drain_pause();
        test_random_traffic();

        release_input();
        wait_results_drained();
        repeat (4 * LATENCY) @(posedge i_clk);
        if (pending_hits.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_hits.size()));
        if (mismatch_count == 0) begin
            $display("obb_aabb_overlap_test_unit verification clean");
        end else begin
            $display("obb_aabb_overlap_test_unit verification failed");
        end
        $finish;
    end

endmodule
